// ===== hw/rtl/rtt_pkg.sv =====
// ----------------------------------------------------------------------------
// Retransmit tracking table package
// Shared constants, codes and the command and status types that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rtt_pkg;

  // Widths of the item fields.
  localparam int ID_W  = 16;
  localparam int EXP_W = 16;
  localparam int MS_W  = 32;

  // Table size default and the cap on results caused by one tick.
  localparam int TABLE_DEPTH_DEF = 16;
  localparam int MAX_RESULTS     = 16;
  localparam int BUF_W           = $clog2(MAX_RESULTS);
  localparam int CNT_W           = $clog2(MAX_RESULTS + 1);

  // Expiry arithmetic.
  localparam logic [MS_W-1:0] MS_PER_S          = 32'd1000;
  localparam logic [MS_W-1:0] DEFAULT_EXPIRY_MS = 32'd86400000;

  // Configuration register defaults and indexes.
  localparam int PADDR_W = 4;
  localparam logic [7:0]  MAX_RETRIES_RST    = 8'd3;
  localparam logic [15:0] RETRY_INTERVAL_RST = 16'd1000;
  localparam logic        SENDER_PRESENT_RST = 1'b0;

  typedef enum logic [1:0] {
    REG_MAX_RETRIES    = 2'd0,
    REG_RETRY_INTERVAL = 2'd1,
    REG_SENDER_PRESENT = 2'd2
  } reg_index_t;

  // Input command codes.
  typedef enum logic [1:0] {
    CMD_SEND = 2'd0,
    CMD_ACK  = 2'd1,
    CMD_TICK = 2'd2
  } cmd_code_t;

  // Result kinds.
  localparam logic KIND_TX     = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // Source of the success bit of an emitted result.
  typedef enum logic [1:0] {
    OK_ZERO = 2'd0,
    OK_SEND = 2'd1,
    OK_ACK  = 2'd2
  } ok_sel_t;

  typedef struct packed {
    logic [7:0]  max_retries;
    logic [15:0] retry_interval;
    logic        sender_present;
  } cfg_t;

  // One stored table entry.
  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [MS_W-1:0] last_sent;
    logic [MS_W-1:0] expiry;
    logic [7:0]      retry_count;
    logic [7:0]      retry_limit;
    logic [15:0]     interval;
  } entry_t;

  typedef struct packed {
    logic    en;
    logic    from_buf;
    logic    kind;
    ok_sel_t ok_sel;
    logic    last;
  } emit_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  capture;
    logic  idx_inc;
    logic  tick_now;
    logic  find_note;
    logic  ack_clr;
    logic  tick_apply;
    logic  send_write;
    emit_t emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] code;
    logic       needs_ack;
    logic       sender_present;
    logic       idx_last;
    logic       ev_match;
    logic       have_slot;
    logic       res_full;
    logic       buf_empty;
    logic       buf_last;
    logic       out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rtt_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one command item into the table.
// ----------------------------------------------------------------------------
`default_nettype none

interface rtt_req_if import rtt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       command;
  logic [ID_W-1:0]  msg_id;
  logic             needs_ack;
  logic [EXP_W-1:0] expire_after_s;
  logic             ack_success;
  logic             send_ok;

  modport source (output valid, command, msg_id, needs_ack, expire_after_s,
                  ack_success, send_ok, input ready);
  modport sink (input valid, command, msg_id, needs_ack, expire_after_s,
                ack_success, send_ok, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rtt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries transmit requests and completion reports.
// ----------------------------------------------------------------------------
`default_nettype none

interface rtt_rsp_if import rtt_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            kind;
  logic [ID_W-1:0] msg_id_res;
  logic            success;
  logic            last;

  modport source (output valid, kind, msg_id_res, success, last, input ready);
  modport sink (input valid, kind, msg_id_res, success, last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rtt_cfg.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file for retry limit, retry interval and sender flag.
// ----------------------------------------------------------------------------
`default_nettype none

module rtt_cfg import rtt_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  output cfg_t                    cfg
);

  logic       wr_en;
  reg_index_t sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign sel    = reg_index_t'(paddr[3:2]);

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_retries    <= MAX_RETRIES_RST;
      cfg.retry_interval <= RETRY_INTERVAL_RST;
      cfg.sender_present <= SENDER_PRESENT_RST;
    end else if (wr_en) begin
      case (sel)
        REG_MAX_RETRIES:    cfg.max_retries    <= pwdata[7:0];
        REG_RETRY_INTERVAL: cfg.retry_interval <= pwdata[15:0];
        REG_SENDER_PRESENT: cfg.sender_present <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read data.
  always_comb begin
    case (sel)
      REG_MAX_RETRIES:    prdata = {24'd0, cfg.max_retries};
      REG_RETRY_INTERVAL: prdata = {16'd0, cfg.retry_interval};
      REG_SENDER_PRESENT: prdata = {31'd0, cfg.sender_present};
      default:            prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rtt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Table controller
// State machine that sequences sends, acknowledgments, tick scans and the
// delivery of results, one item at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module rtt_ctrl import rtt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [15:0] {
    ST_IDLE     = 16'h0001,
    ST_DISPATCH = 16'h0002,
    ST_S_RD     = 16'h0004,
    ST_S_EV     = 16'h0008,
    ST_S_WR     = 16'h0010,
    ST_A_RD     = 16'h0020,
    ST_A_EV     = 16'h0040,
    ST_T_RD     = 16'h0080,
    ST_T_EV     = 16'h0100,
    ST_T_OUT    = 16'h0200,
    ST_EM_TX1   = 16'h0400,
    ST_EM_SEND  = 16'h0800,
    ST_EM_TXL   = 16'h1000,
    ST_EM_FAIL  = 16'h2000,
    ST_EM_ACK   = 16'h4000,
    ST_EM_BUF   = 16'h8000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  assign in_ready = (state == ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (cmd_code_t'(sts.code))
          CMD_SEND: begin
            if (!sts.sender_present) state_next = ST_EM_FAIL;
            else if (!sts.needs_ack) state_next = ST_EM_TX1;
            else                     state_next = ST_S_RD;
          end
          CMD_ACK:  state_next = ST_A_RD;
          CMD_TICK: begin
            cmd.tick_now = 1'b1;
            state_next   = ST_T_RD;
          end
          default:  state_next = ST_IDLE;
        endcase
      end
      // Send scan: find a matching entry and the lowest free one.
      ST_S_RD: state_next = ST_S_EV;
      ST_S_EV: begin
        cmd.find_note = 1'b1;
        if (sts.idx_last) begin
          state_next = ST_S_WR;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = ST_S_RD;
        end
      end
      ST_S_WR: begin
        if (sts.have_slot) begin
          cmd.send_write = 1'b1;
          state_next     = ST_EM_TXL;
        end else begin
          state_next = ST_EM_FAIL;
        end
      end
      // Acknowledgment scan stops at the first match.
      ST_A_RD: state_next = ST_A_EV;
      ST_A_EV: begin
        if (sts.ev_match) begin
          cmd.ack_clr = 1'b1;
          state_next  = ST_EM_ACK;
        end else if (sts.idx_last) begin
          state_next = ST_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = ST_A_RD;
        end
      end
      // Tick scan, bounded by the result cap.
      ST_T_RD: begin
        if (sts.res_full) state_next = ST_T_OUT;
        else              state_next = ST_T_EV;
      end
      ST_T_EV: begin
        cmd.tick_apply = 1'b1;
        if (sts.idx_last) begin
          state_next = ST_T_OUT;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = ST_T_RD;
        end
      end
      ST_T_OUT: begin
        if (sts.buf_empty) state_next = ST_IDLE;
        else               state_next = ST_EM_BUF;
      end
      // Result delivery, each waits for a free output register.
      ST_EM_TX1: begin
        if (sts.out_free) begin
          cmd.emit   = '{en: 1'b1, from_buf: 1'b0, kind: KIND_TX, ok_sel: OK_ZERO,
                         last: 1'b0};
          state_next = ST_EM_SEND;
        end
      end
      ST_EM_SEND: begin
        if (sts.out_free) begin
          cmd.emit   = '{en: 1'b1, from_buf: 1'b0, kind: KIND_REPORT, ok_sel: OK_SEND,
                         last: 1'b1};
          state_next = ST_IDLE;
        end
      end
      ST_EM_TXL: begin
        if (sts.out_free) begin
          cmd.emit   = '{en: 1'b1, from_buf: 1'b0, kind: KIND_TX, ok_sel: OK_ZERO,
                         last: 1'b1};
          state_next = ST_IDLE;
        end
      end
      ST_EM_FAIL: begin
        if (sts.out_free) begin
          cmd.emit   = '{en: 1'b1, from_buf: 1'b0, kind: KIND_REPORT, ok_sel: OK_ZERO,
                         last: 1'b1};
          state_next = ST_IDLE;
        end
      end
      ST_EM_ACK: begin
        if (sts.out_free) begin
          cmd.emit   = '{en: 1'b1, from_buf: 1'b0, kind: KIND_REPORT, ok_sel: OK_ACK,
                         last: 1'b1};
          state_next = ST_IDLE;
        end
      end
      ST_EM_BUF: begin
        if (sts.out_free) begin
          cmd.emit   = '{en: 1'b1, from_buf: 1'b1, kind: KIND_TX, ok_sel: OK_ZERO,
                         last: 1'b0};
          if (sts.buf_last) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rtt_dp.sv =====
// ----------------------------------------------------------------------------
// Table datapath
// Entry memory, valid bits, millisecond clock, scan index, per-tick result
// buffer and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rtt_dp import rtt_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cfg_t             cfg,
  input  wire cmd_t             cmd,
  output sts_t                  sts,
  input  wire logic [1:0]       in_command,
  input  wire logic [ID_W-1:0]  in_msg_id,
  input  wire logic             in_needs_ack,
  input  wire logic [EXP_W-1:0] in_expire_after_s,
  input  wire logic             in_ack_success,
  input  wire logic             in_send_ok,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_kind,
  output logic [ID_W-1:0]       out_msg_id,
  output logic                  out_success,
  output logic                  out_last
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);

  // Captured item.
  logic [1:0]      cap_cmd;
  logic [ID_W-1:0] cap_id;
  logic            cap_needs_ack;
  logic            cap_ack_ok;
  logic            cap_send_ok;
  logic [MS_W-1:0] exp_ofs;

  logic [MS_W-1:0]        now;
  logic [TABLE_DEPTH-1:0] valid;
  logic [IDX_W-1:0]       idx;
  entry_t                 mem [TABLE_DEPTH];
  entry_t                 rd_q;

  logic             match_found, free_found;
  logic [IDX_W-1:0] match_slot, free_slot;

  logic [CNT_W-1:0] nrep, ntx, ptr, total, tx_off;
  logic [ID_W-1:0]  buf_id [MAX_RESULTS];

  // Entry evaluation.
  logic            ev_valid, ev_match, expire, due, drop, retry;
  logic [MS_W-1:0] d_exp, d_sent;

  assign ev_valid = valid[idx];
  assign ev_match = ev_valid && (rd_q.id == cap_id);
  assign d_exp    = now - rd_q.expiry;
  assign d_sent   = now - rd_q.last_sent;
  assign expire   = (d_exp != '0) && !d_exp[MS_W-1];
  assign due      = d_sent >= {16'd0, rd_q.interval};
  assign drop     = !expire && due && (rd_q.retry_count >= rd_q.retry_limit);
  assign retry    = !expire && due && (rd_q.retry_count < rd_q.retry_limit);

  // Memory write port.
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  entry_t           mem_wd;
  logic [IDX_W-1:0] slot;

  assign slot = match_found ? match_slot : free_slot;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx;
    mem_wd = rd_q;
    if (cmd.send_write) begin
      mem_we = 1'b1;
      mem_wa = slot;
      mem_wd = '{id: cap_id, last_sent: now, expiry: now + exp_ofs, retry_count: 8'd0,
                 retry_limit: cfg.max_retries, interval: cfg.retry_interval};
    end else if (cmd.tick_apply && ev_valid && retry) begin
      mem_we              = 1'b1;
      mem_wd.retry_count  = rd_q.retry_count + 8'd1;
      mem_wd.last_sent    = now;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_q <= mem[idx];
  end

  // Captured item and the expiry offset.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_cmd       <= in_command;
      cap_id        <= in_msg_id;
      cap_needs_ack <= in_needs_ack;
      cap_ack_ok    <= in_ack_success;
      cap_send_ok   <= in_send_ok;
      exp_ofs       <= (in_expire_after_s == '0) ? DEFAULT_EXPIRY_MS
                                                 : MS_W'(in_expire_after_s) * MS_PER_S;
    end
  end

  // Clock, valid bits, scan index and slot search.
  always_ff @(posedge clk) begin
    if (rst) begin
      now         <= '0;
      valid       <= '0;
      idx         <= '0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
      match_slot  <= '0;
      free_slot   <= '0;
    end else begin
      if (cmd.capture) begin
        idx         <= '0;
        match_found <= 1'b0;
        free_found  <= 1'b0;
      end else if (cmd.idx_inc) begin
        idx <= idx + IDX_W'(1);
      end
      if (cmd.tick_now) now <= now + MS_W'(1);
      if (cmd.find_note) begin
        if (!match_found && ev_match) begin
          match_found <= 1'b1;
          match_slot  <= idx;
        end
        if (!free_found && !ev_valid) begin
          free_found <= 1'b1;
          free_slot  <= idx;
        end
      end
      if (cmd.send_write) valid[slot] <= 1'b1;
      if (cmd.ack_clr) valid[idx] <= 1'b0;
      if (cmd.tick_apply && ev_valid && (expire || drop)) valid[idx] <= 1'b0;
    end
  end

  // Tick result buffer: reports fill upward, transmit requests downward.
  assign total  = nrep + ntx;
  assign tx_off = ptr - nrep;

  always_ff @(posedge clk) begin
    if (rst) begin
      nrep <= '0;
      ntx  <= '0;
      ptr  <= '0;
    end else begin
      if (cmd.capture) begin
        nrep <= '0;
        ntx  <= '0;
        ptr  <= '0;
      end else begin
        if (cmd.tick_apply && ev_valid) begin
          if (expire || drop) nrep <= nrep + CNT_W'(1);
          else if (retry)     ntx  <= ntx + CNT_W'(1);
        end
        if (cmd.emit.en && cmd.emit.from_buf) ptr <= ptr + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_apply && ev_valid) begin
      if (expire || drop) buf_id[nrep[BUF_W-1:0]] <= rd_q.id;
      else if (retry)     buf_id[BUF_W'(MAX_RESULTS - 1) - ntx[BUF_W-1:0]] <= rd_q.id;
    end
  end

  // Output register.
  logic            buf_is_rep;
  logic [ID_W-1:0] buf_rd;

  assign buf_is_rep = ptr < nrep;
  assign buf_rd     = buf_is_rep ? buf_id[ptr[BUF_W-1:0]]
                                 : buf_id[BUF_W'(MAX_RESULTS - 1) - tx_off[BUF_W-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit.en) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit.en) begin
      if (cmd.emit.from_buf) begin
        out_kind    <= buf_is_rep ? KIND_REPORT : KIND_TX;
        out_msg_id  <= buf_rd;
        out_success <= 1'b0;
        out_last    <= (ptr == total - CNT_W'(1));
      end else begin
        out_kind   <= cmd.emit.kind;
        out_msg_id <= cap_id;
        out_last   <= cmd.emit.last;
        case (cmd.emit.ok_sel)
          OK_SEND: out_success <= cap_send_ok;
          OK_ACK:  out_success <= cap_ack_ok;
          default: out_success <= 1'b0;
        endcase
      end
    end
  end

  // Status to the controller.
  always_comb begin
    sts.code           = cap_cmd;
    sts.needs_ack      = cap_needs_ack;
    sts.sender_present = cfg.sender_present;
    sts.idx_last       = (idx == IDX_W'(TABLE_DEPTH - 1));
    sts.ev_match       = ev_match;
    sts.have_slot      = match_found || free_found;
    sts.res_full       = (total == CNT_W'(MAX_RESULTS));
    sts.buf_empty      = (total == '0);
    sts.buf_last       = (ptr == total - CNT_W'(1));
    sts.out_free       = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/retransmit_tracking_table.sv =====
// Scans: a tracked send reads and evaluates every entry in turn; an ack scans
// up to the first match; a tick scans up to the last entry or the result cap,
// then delivers its results. The entry memory gives one entry per scan step.
// Throughput: one item at a time; the next item is taken once the last result
// sits in the output register. Reset (synchronous) clears the valid bits, the
// clock and the registers to their defaults; there is no clearing pass.
// ----------------------------------------------------------------------------
// Retransmit tracking table
// Tracks messages awaiting acknowledgment and retries or expires them on
// millisecond ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module retransmit_tracking_table import rtt_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  rtt_req_if.sink                 req,
  rtt_rsp_if.source               rsp
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  rtt_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  rtt_ctrl u_ctrl (
    .clk, .rst,
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts,
    .cmd
  );

  rtt_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk, .rst, .cfg, .cmd, .sts,
    .in_command        (req.command),
    .in_msg_id         (req.msg_id),
    .in_needs_ack      (req.needs_ack),
    .in_expire_after_s (req.expire_after_s),
    .in_ack_success    (req.ack_success),
    .in_send_ok        (req.send_ok),
    .out_valid         (rsp.valid),
    .out_ready         (rsp.ready),
    .out_kind          (rsp.kind),
    .out_msg_id        (rsp.msg_id_res),
    .out_success       (rsp.success),
    .out_last          (rsp.last)
  );

`ifndef ASSERT_OFF
  // A result is only loaded when the output register can take it.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit.en |-> sts.out_free) else $error("result loaded over a pending one");

  // A tracked send writes only when a slot was found.
  a_send_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.send_write |-> sts.have_slot) else $error("send written without a slot");

  // The tick scan never acts past the result cap.
  a_tick_cap: assert property (@(posedge clk) disable iff (rst)
    cmd.tick_apply |-> !sts.res_full) else $error("tick scan past result cap");

  // No new item is captured while a scan step is under way.
  a_capture_alone: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> !(cmd.tick_apply || cmd.find_note || cmd.emit.en))
    else $error("capture overlaps other work");
`endif

endmodule

`default_nettype wire
